// ----- sv/mppa_pkg.sv -----
// Shared constants, types and state codes of the modular power product accumulator.
package mppa_pkg;

    // Field widths
    localparam int BASE_W    = 31;
    localparam int EXPIN_W   = 32;
    localparam int PROD_W    = 30;

    // Digit-serial multiplier: two multiplier bits per cycle, most significant first
    localparam int DIGIT_W    = 2;
    localparam int NUM_DIGITS = PROD_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(NUM_DIGITS);
    localparam logic [DCNT_W-1:0] DCNT_ONE  = DCNT_W'(1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_DIGITS - 1);

    // Partial sum 4*p + 3*a stays below 7*P, which fits in 33 bits
    localparam int EXT_W    = PROD_W + 3;
    localparam int MAX_FOLD = 6;

    localparam logic [PROD_W-1:0] MODULUS  = PROD_W'(1000000007);
    localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(1);

    // Multiples of the prime, used to fold a partial sum back below the prime
    localparam logic [EXT_W-1:0] MOD_MULT [MAX_FOLD] = '{
        33'd1000000007,
        33'd2000000014,
        33'd3000000021,
        33'd4000000028,
        33'd5000000035,
        33'd6000000042
    };

    // Multiples of the prime for folding a raw base
    localparam logic [BASE_W-1:0] MOD_BASE1 = 31'd1000000007;
    localparam logic [BASE_W-1:0] MOD_BASE2 = 31'd2000000014;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_MUL  = 3'b100
    } state_t;

endpackage

// ----- sv/modular_power_product_accumulator_unit.sv -----
// Top level: running product times base to the exponent, modulo 1000000007, digit serial.
// An accepted request runs, per exponent bit up to its highest set bit (at most EXP_WIDTH
//   bits), one check state and the 2-bit digit loop of the paired modular multipliers
//   (15 digits); a last check loads the result register once the previous result is taken.
//   A new request is taken only after that, when the unit is back in idle.
// Reset: synchronous, active low; clears the handshake state and sets the product to 1.
module modular_power_product_accumulator_unit #(
    parameter int EXP_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mppa_pkg::BASE_W-1:0]   s_base,
    input  logic [mppa_pkg::EXPIN_W-1:0]  s_exponent,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mppa_pkg::PROD_W-1:0]   m_product
);

    localparam int PW = mppa_pkg::PROD_W;

    // Fold a raw base (below three times the prime) into range
    function automatic logic [PW-1:0] reduce_base(input logic [mppa_pkg::BASE_W-1:0] b);
        logic [mppa_pkg::BASE_W-1:0] r;
        r = b;
        if (b >= mppa_pkg::MOD_BASE2) begin
            r = b - mppa_pkg::MOD_BASE2;
        end else if (b >= mppa_pkg::MOD_BASE1) begin
            r = b - mppa_pkg::MOD_BASE1;
        end
        return r[PW-1:0];
    endfunction

    // One digit of an interleaved modular multiply: (4*p + d*a) mod P
    function automatic logic [PW-1:0] digit_step(
        input logic [PW-1:0]                  p,
        input logic [PW-1:0]                  a,
        input logic [mppa_pkg::DIGIT_W-1:0]   d
    );
        logic [mppa_pkg::EXT_W-1:0] t;
        logic [mppa_pkg::EXT_W-1:0] r;
        t = {1'b0, p, 2'b00};
        if (d[1]) begin
            t = t + {2'b00, a, 1'b0};
        end
        if (d[0]) begin
            t = t + {3'b000, a};
        end
        r = t;
        for (int k = 0; k < mppa_pkg::MAX_FOLD; k++) begin
            if (t >= mppa_pkg::MOD_MULT[k]) begin
                r = t - mppa_pkg::MOD_MULT[k];
            end
        end
        return r[PW-1:0];
    endfunction

    mppa_pkg::state_t state_reg, state_next;

    logic [PW-1:0]                 acc_reg, acc_next;
    logic [PW-1:0]                 base_reg, base_next;
    logic [EXP_WIDTH-1:0]          exp_reg, exp_next;
    logic [PW-1:0]                 mul_sr_reg, mul_sr_next;
    logic [PW-1:0]                 pa_reg, pa_next;
    logic [PW-1:0]                 pb_reg, pb_next;
    logic [mppa_pkg::DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic [PW-1:0]                 m_product_reg, m_product_next;

    logic [EXP_WIDTH-1:0]          exp_in;
    logic [mppa_pkg::DIGIT_W-1:0]  digit;
    logic [PW-1:0]                 pa_step;
    logic [PW-1:0]                 pb_step;
    logic                          publish;

    // Keep only the exponent bits that take part
    generate
        if (EXP_WIDTH <= mppa_pkg::EXPIN_W) begin : g_exp_narrow
            assign exp_in = s_exponent[EXP_WIDTH-1:0];
        end else begin : g_exp_wide
            assign exp_in = {{(EXP_WIDTH - mppa_pkg::EXPIN_W){1'b0}}, s_exponent};
        end
    endgenerate

    // Both multipliers share the base as multiplier: acc*base and base*base
    assign digit   = mul_sr_reg[PW-1 -: mppa_pkg::DIGIT_W];
    assign pa_step = digit_step(pa_reg, acc_reg, digit);
    assign pb_step = digit_step(pb_reg, base_reg, digit);

    // Sequence the square-and-multiply steps
    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        mul_sr_next    = mul_sr_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        dcnt_next      = dcnt_reg;
        m_product_next = m_product_reg;
        publish        = 1'b0;
        unique case (state_reg)
            mppa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart) begin
                        acc_next = mppa_pkg::PROD_ONE;
                    end
                    base_next  = reduce_base(s_base);
                    exp_next   = exp_in;
                    state_next = mppa_pkg::ST_EVAL;
                end
            end
            mppa_pkg::ST_EVAL: begin
                if (exp_reg == '0) begin
                    if (!m_valid_reg || m_ready) begin
                        m_product_next = acc_reg;
                        publish        = 1'b1;
                        state_next     = mppa_pkg::ST_IDLE;
                    end
                end else begin
                    mul_sr_next = base_reg;
                    pa_next     = '0;
                    pb_next     = '0;
                    dcnt_next   = '0;
                    state_next  = mppa_pkg::ST_MUL;
                end
            end
            mppa_pkg::ST_MUL: begin
                pa_next     = pa_step;
                pb_next     = pb_step;
                mul_sr_next = {mul_sr_reg[PW-mppa_pkg::DIGIT_W-1:0],
                               {mppa_pkg::DIGIT_W{1'b0}}};
                dcnt_next   = dcnt_reg + mppa_pkg::DCNT_ONE;
                if (dcnt_reg == mppa_pkg::DCNT_LAST) begin
                    if (exp_reg[0]) begin
                        acc_next = pa_step;
                    end
                    base_next  = pb_step;
                    exp_next   = exp_reg >> 1;
                    state_next = mppa_pkg::ST_EVAL;
                end
            end
            default: begin
                state_next = mppa_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold a result until it is taken
    always_comb begin
        priority if (publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mppa_pkg::ST_IDLE;
            acc_reg     <= mppa_pkg::PROD_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        exp_reg       <= exp_next;
        mul_sr_reg    <= mul_sr_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        dcnt_reg      <= dcnt_next;
        m_product_reg <= m_product_next;
    end

    assign s_ready   = (state_reg == mppa_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_product = m_product_reg;

endmodule

// ----- sv/mppa_checker.sv -----
// Port-level checker for the modular power product accumulator, with its bind.
module mppa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mppa_pkg::PROD_W-1:0]   m_product
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product))
    else $error("result changed while stalled");

    // Every result lies below the prime
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_product < mppa_pkg::MODULUS)
    else $error("result not reduced");

    // One request at a time: busy right after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
    else $error("request taken while busy");

    // Ready returns only together with a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> m_valid)
    else $error("ready returned without a result");

endmodule

bind modular_power_product_accumulator_unit mppa_checker u_mppa_checker (.*);
